>>> rtl/core/gn3o_pkg.sv
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
// No dependencies; every file of the block but the interfaces imports this package.
package gn3o_pkg;

   // Permutation table geometry, fixed by the 9-bit entry fields.
   localparam int TBL_AW    = 9;
   localparam int TBL_DEPTH = 512;
   localparam int PERM_W    = 9;

   // Fixed-point widths: Q0.16 fractions, signed gradient and blend values, result.
   localparam int FRAC_W  = 16;
   localparam int GRAD_W  = 19;
   localparam int QUOT_W  = 16;
   localparam int OUT_W   = 16;
   localparam int COORD_W = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_AW  = 3;

   // Fade polynomial coefficients: 10*2^16 - 15 t + 6 t^2.
   localparam logic [19:0] FADE_K0  = 20'd655360;
   localparam logic [19:0] FADE_C15 = 20'd15;
   localparam logic [19:0] FADE_C6  = 20'd6;

   // One unit in Q16, used for the far corner offsets.
   localparam logic signed [GRAD_W-1:0] ONE_Q16 = 19'sd65536;

   localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

   localparam logic [3:0] OCT_RESET = 4'd8;

   typedef enum logic {
      OP_EVAL = 1'b0,
      OP_LOAD = 1'b1
   } opcode_type;

   typedef enum logic {
      MODE_SINGLE = 1'b0,
      MODE_OCTAVE = 1'b1
   } mode_type;

   typedef enum logic {
      REG_MODE    = 1'b0,
      REG_OCTAVES = 1'b1
   } reg_index_type;

   // Control that travels with every pipeline slot.
   typedef struct packed {
      logic valid;
      logic is_load;
      logic octave;
      logic first;
      logic last;
   } stage_ctl_type;

   // Side information that travels through the divider alongside the remainder.
   typedef struct packed {
      logic                     octave;
      logic                     negative;
      logic signed [OUT_W-1:0]  single_value;
   } div_tag_type;

   // Dot product of a corner offset with the cube-edge gradient that the low hash bits select.
   function automatic logic signed [GRAD_W-1:0] grad_dot(
      input logic [3:0]               h,
      input logic signed [GRAD_W-1:0] x,
      input logic signed [GRAD_W-1:0] y,
      input logic signed [GRAD_W-1:0] z
   );
      logic signed [GRAD_W-1:0] u;
      logic signed [GRAD_W-1:0] v;
      logic signed [GRAD_W-1:0] su;
      logic signed [GRAD_W-1:0] sv;
      u = (h < 4'd8) ? x : y;
      if (h < 4'd4) begin
         v = y;
      end else if ((h == 4'd12) || (h == 4'd14)) begin
         v = x;
      end else begin
         v = z;
      end
      su = h[0] ? -u : u;
      sv = h[1] ? -v : v;
      return su + sv;
   endfunction

   // a + floor(f * (b - a) / 2^16); the result always lies between a and b.
   function automatic logic signed [GRAD_W-1:0] lerp_q16(
      input logic [FRAC_W-1:0]        f,
      input logic signed [GRAD_W-1:0] a,
      input logic signed [GRAD_W-1:0] b
   );
      logic signed [GRAD_W:0]          d;
      logic signed [FRAC_W+GRAD_W+1:0] p;
      d = {b[GRAD_W-1], b} - {a[GRAD_W-1], a};
      p = $signed({1'b0, f}) * d;
      return a + $signed(p[FRAC_W+GRAD_W-1:FRAC_W]);
   endfunction

endpackage

>>> rtl/core/gn3o_if.sv
// Request and response channel interfaces of the gradient noise block.
// Depends on nothing; widths follow the request and response fields.
interface gn3o_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] x_coord;
   logic signed [31:0] y_coord;
   logic signed [31:0] z_coord;
   logic [8:0]         entry_index;
   logic [8:0]         entry_value;

   modport source (output valid, opcode, x_coord, y_coord, z_coord, entry_index, entry_value,
                   input ready);
   modport sink   (input valid, opcode, x_coord, y_coord, z_coord, entry_index, entry_value,
                   output ready);
endinterface

interface gn3o_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

>>> rtl/core/gn3o_perm_ram.sv
// One copy of the permutation table: one write port, two registered read ports.
// Depends on gn3o_pkg for the table geometry.
module gn3o_perm_ram import gn3o_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic              write_en,
   input  logic [TBL_AW-1:0] write_addr,
   input  logic [PERM_W-1:0] write_data,
   input  logic [TBL_AW-1:0] read_addr_a,
   input  logic [TBL_AW-1:0] read_addr_b,
   output logic [PERM_W-1:0] read_data_a,
   output logic [PERM_W-1:0] read_data_b
);

   logic [PERM_W-1:0] mem_ff [TBL_DEPTH];
   logic [PERM_W-1:0] rdata_a_ff;
   logic [PERM_W-1:0] rdata_b_ff;

   // Table storage; reads are held while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (enable) begin
         rdata_a_ff <= mem_ff[read_addr_a];
         rdata_b_ff <= mem_ff[read_addr_b];
      end
   end

   assign read_data_a = rdata_a_ff;
   assign read_data_b = rdata_b_ff;

endmodule

>>> rtl/core/gn3o_div_pipe.sv
// Pipelined restoring divider for the octave normalisation, one quotient bit per stage,
// followed by sign restoration, saturation and the output register. Depends on gn3o_pkg.
module gn3o_div_pipe import gn3o_pkg::*; #(
   parameter int REM_W = 27
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  div_tag_type             in_tag,
   input  logic [REM_W-1:0]        in_rem,
   input  logic [REM_W-1:0]        divisor,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_value
);

   logic              val_ff [QUOT_W+1];
   logic [REM_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] quo_ff [QUOT_W+1];
   div_tag_type       tag_ff [QUOT_W+1];

   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_value_ff;
   logic signed [OUT_W-1:0] out_value_in;
   logic [QUOT_W-1:0]       quo_last;

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (advance) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= in_rem;
         quo_ff[0] <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   // One compare and subtract per stage, most significant quotient bit first.
   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      localparam int J = QUOT_W - 1 - k;
      logic [REM_W-1:0] trial;
      logic             fits;

      assign trial = divisor << J;
      assign fits  = (rem_ff[k] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (advance) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= fits ? (rem_ff[k] - trial) : rem_ff[k];
            quo_ff[k+1] <= quo_ff[k] | (QUOT_W'(fits) << J);
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   // Restore the sign of the quotient and clip the positive side; single mode passes through.
   assign quo_last = quo_ff[QUOT_W];

   always_comb begin
      if (!tag_ff[QUOT_W].octave) begin
         out_value_in = tag_ff[QUOT_W].single_value;
      end else if (tag_ff[QUOT_W].negative) begin
         out_value_in = -$signed(quo_last);
      end else if (quo_last[QUOT_W-1]) begin
         out_value_in = SAT_MAX;
      end else begin
         out_value_in = $signed(quo_last);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= val_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= out_value_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule

>>> rtl/core/gradient_noise_3d_octaves.sv
// Fixed-point improved gradient noise with a loadable permutation table.
// A request passes the lookup, fade and blend stages, then the divider; a stall holds it.
// Throughput, unless a stall holds the pipeline: one request per cycle in single mode and for
// table loads; an octave-mode request stays at the input for one pipeline pass per octave.
// Reset clears the pipeline valid bits and sets mode to single and the octave count to 8;
// the table itself is not cleared and must be loaded before it is read.
module gradient_noise_3d_octaves import gn3o_pkg::*; #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic              clock,
   input  logic              reset,
   gn3o_req_if.sink          req,
   gn3o_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   localparam int PASS_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int ACC_W  = GRAD_W + MAX_OCTAVES;
   localparam int REM_W  = ACC_W;
   localparam int AX_X   = 0;
   localparam int AX_Y   = 1;
   localparam int AX_Z   = 2;

   // ---------------- configuration registers ----------------
   mode_type      mode_ff;
   mode_type      mode_in;
   logic [3:0]    octcnt_ff;
   logic [3:0]    octcnt_in;
   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   // Register write decode.
   always_comb begin
      mode_in   = mode_ff;
      octcnt_in = octcnt_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MODE:    mode_in   = mode_type'(csr_pwdata[0]);
            REG_OCTAVES: octcnt_in = csr_pwdata[3:0];
            default:     mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SINGLE;
         octcnt_ff <= OCT_RESET;
      end else begin
         mode_ff   <= mode_in;
         octcnt_ff <= octcnt_in;
      end
   end

   // Register read decode.
   always_comb begin
      unique case (csr_index)
         REG_MODE:    csr_prdata = {{(CSR_W-1){1'b0}}, mode_ff};
         REG_OCTAVES: csr_prdata = {{(CSR_W-4){1'b0}}, octcnt_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Octave count clamped to the supported range, and the normalising divisor 4*(2^n - 1).
   logic [OCT_W-1:0] n_eff;
   logic [REM_W-1:0] divisor;

   always_comb begin
      if (octcnt_ff == 4'd0) begin
         n_eff = OCT_W'(1);
      end else if ({1'b0, octcnt_ff} > 5'(MAX_OCTAVES)) begin
         n_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         n_eff = OCT_W'(octcnt_ff);
      end
   end

   assign divisor = ((REM_W'(1) << n_eff) - REM_W'(1)) << 2;

   // ---------------- input sequencer ----------------
   logic              adv;
   logic              rsp_valid;
   opcode_type        req_op;
   logic              octave_eval;
   logic              last_pass;
   logic [PASS_W-1:0] pass_cnt_ff;
   logic [PASS_W-1:0] pass_cnt_in;
   logic [PASS_W-1:0] shift_amt;
   logic [COORD_W-1:0] scaled [3];
   stage_ctl_type     s0_ctl;

   // The whole pipeline moves together unless a finished result is left waiting.
   assign adv         = !rsp_valid || rsp.ready;
   assign req_op      = opcode_type'(req.opcode);
   assign octave_eval = req.valid && (req_op == OP_EVAL) && (mode_ff == MODE_OCTAVE);
   assign last_pass   = (pass_cnt_ff == PASS_W'(n_eff - OCT_W'(1)));
   assign req.ready   = adv && !(octave_eval && !last_pass);

   // Octave pass counter; the request is only taken with its last pass.
   always_comb begin
      pass_cnt_in = pass_cnt_ff;
      if (adv && octave_eval) begin
         pass_cnt_in = last_pass ? '0 : pass_cnt_ff + PASS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_cnt_ff <= '0;
      end else begin
         pass_cnt_ff <= pass_cnt_in;
      end
   end

   // Frequency scaling by 2^i only affects the low 25 bits that the cell and fraction use.
   assign shift_amt = (mode_ff == MODE_OCTAVE) ? pass_cnt_ff : '0;

   always_comb begin
      scaled[AX_X] = COORD_W'(req.x_coord) << shift_amt;
      scaled[AX_Y] = COORD_W'(req.y_coord) << shift_amt;
      scaled[AX_Z] = (mode_ff == MODE_OCTAVE) ? '0 : COORD_W'(req.z_coord);
   end

   always_comb begin
      s0_ctl.valid   = req.valid;
      s0_ctl.is_load = (req_op == OP_LOAD);
      s0_ctl.octave  = (mode_ff == MODE_OCTAVE);
      s0_ctl.first   = (pass_cnt_ff == '0);
      s0_ctl.last    = (mode_ff != MODE_OCTAVE) || last_pass;
   end

   // ---------------- table lookups, first level ----------------
   logic [TBL_AW-1:0] cell_x;
   logic [PERM_W-1:0] p_x;
   logic [PERM_W-1:0] p_x1;
   logic              load_take;

   assign cell_x    = scaled[AX_X][FRAC_W+TBL_AW-1:FRAC_W];
   assign load_take = req.valid && req.ready && (req_op == OP_LOAD);

   gn3o_perm_ram u_ram_l1 (
      .clock       (clock),
      .enable      (adv),
      .write_en    (load_take),
      .write_addr  (req.entry_index),
      .write_data  (req.entry_value),
      .read_addr_a (cell_x),
      .read_addr_b (cell_x + TBL_AW'(1)),
      .read_data_a (p_x),
      .read_data_b (p_x1)
   );

   // ---------------- stage 1 ----------------
   stage_ctl_type     s1_ctl_ff;
   logic [TBL_AW-1:0] s1_cy_ff;
   logic [TBL_AW-1:0] s1_cz_ff;
   logic [FRAC_W-1:0] s1_frac_ff [3];
   logic [TBL_AW-1:0] s1_idx_ff;
   logic [PERM_W-1:0] s1_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s0_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cy_ff <= scaled[AX_Y][FRAC_W+TBL_AW-1:FRAC_W];
         s1_cz_ff <= scaled[AX_Z][FRAC_W+TBL_AW-1:FRAC_W];
         for (int a = 0; a < 3; a++) begin
            s1_frac_ff[a] <= scaled[a][FRAC_W-1:0];
         end
         s1_idx_ff <= req.entry_index;
         s1_val_ff <= req.entry_value;
      end
   end

   // Second-level table copies, written as a load passes this stage.
   logic [TBL_AW-1:0] addr_a;
   logic [TBL_AW-1:0] addr_b;
   logic [PERM_W-1:0] p_a;
   logic [PERM_W-1:0] p_a1;
   logic [PERM_W-1:0] p_b;
   logic [PERM_W-1:0] p_b1;
   logic              load_s1;
   logic [FRAC_W-1:0] t2_in [3];

   assign addr_a  = p_x + s1_cy_ff;
   assign addr_b  = p_x1 + s1_cy_ff;
   assign load_s1 = adv && s1_ctl_ff.valid && s1_ctl_ff.is_load;

   gn3o_perm_ram u_ram_l2a (
      .clock       (clock),
      .enable      (adv),
      .write_en    (load_s1),
      .write_addr  (s1_idx_ff),
      .write_data  (s1_val_ff),
      .read_addr_a (addr_a),
      .read_addr_b (addr_a + TBL_AW'(1)),
      .read_data_a (p_a),
      .read_data_b (p_a1)
   );

   gn3o_perm_ram u_ram_l2b (
      .clock       (clock),
      .enable      (adv),
      .write_en    (load_s1),
      .write_addr  (s1_idx_ff),
      .write_data  (s1_val_ff),
      .read_addr_a (addr_b),
      .read_addr_b (addr_b + TBL_AW'(1)),
      .read_data_a (p_b),
      .read_data_b (p_b1)
   );

   // Fade, first product: t^2 in Q0.16.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [2*FRAC_W-1:0] sq;
         sq       = (2*FRAC_W)'(s1_frac_ff[a]) * (2*FRAC_W)'(s1_frac_ff[a]);
         t2_in[a] = sq[2*FRAC_W-1:FRAC_W];
      end
   end

   // ---------------- stage 2 ----------------
   stage_ctl_type     s2_ctl_ff;
   logic [TBL_AW-1:0] s2_cz_ff;
   logic [FRAC_W-1:0] s2_frac_ff [3];
   logic [FRAC_W-1:0] s2_t2_ff [3];
   logic [TBL_AW-1:0] s2_idx_ff;
   logic [PERM_W-1:0] s2_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (adv) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_cz_ff  <= s1_cz_ff;
         s2_frac_ff <= s1_frac_ff;
         s2_t2_ff  <= t2_in;
         s2_idx_ff <= s1_idx_ff;
         s2_val_ff <= s1_val_ff;
      end
   end

   // Third-level table copies: one per cube edge pair, giving the eight corner hashes.
   logic [TBL_AW-1:0] addr_c [4];
   logic [PERM_W-1:0] hash_lo [4];
   logic [PERM_W-1:0] hash_hi [4];
   logic              load_s2;
   logic [FRAC_W-1:0] t3_in [3];
   logic [19:0]       k_in [3];

   assign load_s2   = adv && s2_ctl_ff.valid && s2_ctl_ff.is_load;
   assign addr_c[0] = p_a + s2_cz_ff;
   assign addr_c[1] = p_a1 + s2_cz_ff;
   assign addr_c[2] = p_b + s2_cz_ff;
   assign addr_c[3] = p_b1 + s2_cz_ff;

   for (genvar c = 0; c < 4; c++) begin : g_l3
      gn3o_perm_ram u_ram_l3 (
         .clock       (clock),
         .enable      (adv),
         .write_en    (load_s2),
         .write_addr  (s2_idx_ff),
         .write_data  (s2_val_ff),
         .read_addr_a (addr_c[c]),
         .read_addr_b (addr_c[c] + TBL_AW'(1)),
         .read_data_a (hash_lo[c]),
         .read_data_b (hash_hi[c])
      );
   end

   // Fade, second product t^3 and the quadratic factor 10 - 15 t + 6 t^2.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [2*FRAC_W-1:0] cu;
         cu       = (2*FRAC_W)'(s2_t2_ff[a]) * (2*FRAC_W)'(s2_frac_ff[a]);
         t3_in[a] = cu[2*FRAC_W-1:FRAC_W];
         k_in[a]  = FADE_K0 - (20'(s2_frac_ff[a]) * FADE_C15) + (20'(s2_t2_ff[a]) * FADE_C6);
      end
   end

   // ---------------- stage 3 ----------------
   stage_ctl_type     s3_ctl_ff;
   logic [FRAC_W-1:0] s3_frac_ff [3];
   logic [FRAC_W-1:0] s3_t3_ff [3];
   logic [19:0]       s3_k_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (adv) begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_frac_ff <= s2_frac_ff;
         s3_t3_ff   <= t3_in;
         s3_k_ff    <= k_in;
      end
   end

   // Corner offsets and the eight gradient dot products.
   logic signed [GRAD_W-1:0] off0 [3];
   logic signed [GRAD_W-1:0] off1 [3];
   logic signed [GRAD_W-1:0] grad_in [8];
   logic [FRAC_W-1:0]        fade_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         off0[a] = $signed({{(GRAD_W-FRAC_W){1'b0}}, s3_frac_ff[a]});
         off1[a] = off0[a] - ONE_Q16;
      end
   end

   // Index: bit 0 x side, bit 1 y side, bit 2 z side.
   always_comb begin
      grad_in[0] = grad_dot(hash_lo[0][3:0], off0[AX_X], off0[AX_Y], off0[AX_Z]);
      grad_in[1] = grad_dot(hash_lo[2][3:0], off1[AX_X], off0[AX_Y], off0[AX_Z]);
      grad_in[2] = grad_dot(hash_lo[1][3:0], off0[AX_X], off1[AX_Y], off0[AX_Z]);
      grad_in[3] = grad_dot(hash_lo[3][3:0], off1[AX_X], off1[AX_Y], off0[AX_Z]);
      grad_in[4] = grad_dot(hash_hi[0][3:0], off0[AX_X], off0[AX_Y], off1[AX_Z]);
      grad_in[5] = grad_dot(hash_hi[2][3:0], off1[AX_X], off0[AX_Y], off1[AX_Z]);
      grad_in[6] = grad_dot(hash_hi[1][3:0], off0[AX_X], off1[AX_Y], off1[AX_Z]);
      grad_in[7] = grad_dot(hash_hi[3][3:0], off1[AX_X], off1[AX_Y], off1[AX_Z]);
   end

   // Fade, final product.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [35:0] pr;
         pr         = 36'(s3_t3_ff[a]) * 36'(s3_k_ff[a]);
         fade_in[a] = pr[2*FRAC_W-1:FRAC_W];
      end
   end

   // ---------------- stage 4 ----------------
   stage_ctl_type            s4_ctl_ff;
   logic signed [GRAD_W-1:0] s4_grad_ff [8];
   logic [FRAC_W-1:0]        s4_fade_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (adv) begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_grad_ff <= grad_in;
         s4_fade_ff <= fade_in;
      end
   end

   // ---------------- stage 5: blend along x ----------------
   stage_ctl_type            s5_ctl_ff;
   logic signed [GRAD_W-1:0] s5_bx_ff [4];
   logic [FRAC_W-1:0]        s5_v_ff;
   logic [FRAC_W-1:0]        s5_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else if (adv) begin
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 4; e++) begin
            s5_bx_ff[e] <= lerp_q16(s4_fade_ff[AX_X], s4_grad_ff[2*e], s4_grad_ff[2*e+1]);
         end
         s5_v_ff <= s4_fade_ff[AX_Y];
         s5_w_ff <= s4_fade_ff[AX_Z];
      end
   end

   // ---------------- stage 6: blend along y ----------------
   stage_ctl_type            s6_ctl_ff;
   logic signed [GRAD_W-1:0] s6_by_ff [2];
   logic [FRAC_W-1:0]        s6_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else if (adv) begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_by_ff[0] <= lerp_q16(s5_v_ff, s5_bx_ff[0], s5_bx_ff[1]);
         s6_by_ff[1] <= lerp_q16(s5_v_ff, s5_bx_ff[2], s5_bx_ff[3]);
         s6_w_ff     <= s5_w_ff;
      end
   end

   // ---------------- stage 7: blend along z ----------------
   stage_ctl_type            s7_ctl_ff;
   logic signed [GRAD_W-1:0] s7_noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctl_ff <= '0;
      end else if (adv) begin
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_noise_ff <= lerp_q16(s6_w_ff, s6_by_ff[0], s6_by_ff[1]);
      end
   end

   // ---------------- octave accumulation and divider entry ----------------
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  noise_ext;
   logic signed [GRAD_W-1:0] quarter;
   logic signed [OUT_W-1:0]  single_sat;
   logic                     acc_take;
   logic                     div_in_valid;
   div_tag_type              div_in_tag;
   logic [REM_W-1:0]         div_in_rem;

   // Weights halve with each octave, so the sum is built as acc*2 + noise.
   assign noise_ext = ACC_W'(s7_noise_ff);
   assign acc_in    = s7_ctl_ff.first ? noise_ext : (acc_ff <<< 1) + noise_ext;
   assign acc_take  = adv && s7_ctl_ff.valid && !s7_ctl_ff.is_load && s7_ctl_ff.octave;

   always_ff @(posedge clock) begin
      if (acc_take) begin
         acc_ff <= acc_in;
      end
   end

   // Single mode scales Q16 to Q14 with a floor and clips to the output range.
   assign quarter = s7_noise_ff >>> 2;

   always_comb begin
      if (quarter > GRAD_W'(SAT_MAX)) begin
         single_sat = SAT_MAX;
      end else if (quarter < GRAD_W'(SAT_MIN)) begin
         single_sat = SAT_MIN;
      end else begin
         single_sat = quarter[OUT_W-1:0];
      end
   end

   always_comb begin
      div_in_valid            = s7_ctl_ff.valid && !s7_ctl_ff.is_load &&
                                (!s7_ctl_ff.octave || s7_ctl_ff.last);
      div_in_tag.octave       = s7_ctl_ff.octave;
      div_in_tag.negative     = acc_in[ACC_W-1];
      div_in_tag.single_value = single_sat;
      div_in_rem              = acc_in[ACC_W-1] ? REM_W'(-acc_in) : REM_W'(acc_in);
   end

   gn3o_div_pipe #(
      .REM_W (REM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (div_in_valid),
      .in_tag    (div_in_tag),
      .in_rem    (div_in_rem),
      .divisor   (divisor),
      .out_valid (rsp_valid),
      .out_value (rsp.noise_value)
   );

   assign rsp.valid = rsp_valid;

   // ---------------- assertions ----------------
   // A stall freezes the first pipeline stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (s1_ctl_ff == $past(s1_ctl_ff)))
      else $error("first stage changed during a stall");

   // The octave pass counter only moves while an octave-mode evaluation is issued.
   a_pass_hold: assert property (@(posedge clock) disable iff (reset)
      !(adv && octave_eval) |=> (pass_cnt_ff == $past(pass_cnt_ff)))
      else $error("octave pass counter moved without an octave request");

   // A request held back with the pipeline moving has issued an intermediate octave pass.
   a_partial_pass: assert property (@(posedge clock) disable iff (reset)
      (adv && req.valid && !req.ready) |=>
         (s1_ctl_ff.valid && s1_ctl_ff.octave && !s1_ctl_ff.last))
      else $error("held request did not issue an intermediate octave pass");

endmodule

>>> tb/sv/tb.sv
// Testbench for the gradient noise block: random and directed requests, self-checking.
// Depends on gn3o_pkg, the gn3o_req_if / gn3o_rsp_if interfaces and the block itself.
module tb;
   import gn3o_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 4000;

   typedef struct {
      opcode_type         opcode;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
      logic [8:0]         entry_index;
      logic [8:0]         entry_value;
   } noise_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]  csr_pwdata = '0;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   gn3o_req_if req ();
   gn3o_rsp_if rsp ();

   gradient_noise_3d_octaves uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   noise_request_type  pending_requests[$];
   logic signed [15:0] expected_noise[$];
   logic [8:0]         perm_copy[512];
   mode_type           cur_mode = MODE_SINGLE;
   logic [3:0]         cur_octaves = OCT_RESET;
   int                 error_count = 0;
   int                 eval_count = 0;
   int                 load_count = 0;
   int                 result_count = 0;
   int                 idle_cycles = 0;

   // Fade curve 6t^5 - 15t^4 + 10t^3 in truncating Q0.16.
   function automatic longint fade_of(longint t);
      longint t2;
      longint t3;
      longint k;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      k = 655360 - 15 * t + 6 * t2;
      return (t3 * k) >> 16;
   endfunction

   function automatic longint blend_of(longint f, longint a, longint b);
      return a + ((f * (b - a)) >>> 16);
   endfunction

   function automatic longint perm_of(longint i);
      return longint'(perm_copy[i & 511]);
   endfunction

   function automatic longint grad_of(longint hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint u;
      longint v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   // One 3D noise sample at Q16.16 coordinates, result in signed Q16.
   function automatic longint noise_at(longint xs, longint ys, longint zs);
      longint cx, cy, cz, x0, y0, z0, x1, y1, z1, u, v, w;
      longint a, aa, ab, b, ba, bb, near_v, far_v;
      cx = (xs >>> 16) & 511;
      cy = (ys >>> 16) & 511;
      cz = (zs >>> 16) & 511;
      x0 = xs & 16'hFFFF;
      y0 = ys & 16'hFFFF;
      z0 = zs & 16'hFFFF;
      x1 = x0 - 65536;
      y1 = y0 - 65536;
      z1 = z0 - 65536;
      u = fade_of(x0);
      v = fade_of(y0);
      w = fade_of(z0);
      a = perm_of(cx) + cy;
      aa = perm_of(a) + cz;
      ab = perm_of(a + 1) + cz;
      b = perm_of(cx + 1) + cy;
      ba = perm_of(b) + cz;
      bb = perm_of(b + 1) + cz;
      near_v = blend_of(v,
         blend_of(u, grad_of(perm_of(aa), x0, y0, z0), grad_of(perm_of(ba), x1, y0, z0)),
         blend_of(u, grad_of(perm_of(ab), x0, y1, z0), grad_of(perm_of(bb), x1, y1, z0)));
      far_v = blend_of(v,
         blend_of(u, grad_of(perm_of(aa + 1), x0, y0, z1),
                     grad_of(perm_of(ba + 1), x1, y0, z1)),
         blend_of(u, grad_of(perm_of(ab + 1), x0, y1, z1),
                     grad_of(perm_of(bb + 1), x1, y1, z1)));
      return blend_of(w, near_v, far_v);
   endfunction

   function automatic logic signed [15:0] saturate16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Expected Q2.14 result of an evaluate request under the current settings.
   function automatic logic signed [15:0] noise_prediction(noise_request_type r);
      longint sum;
      int n;
      sum = 0;
      if (cur_mode == MODE_SINGLE) begin
         return saturate16(noise_at(r.x_coord, r.y_coord, r.z_coord) >>> 2);
      end
      n = cur_octaves;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      for (int i = 0; i < n; i++) begin
         sum += noise_at(longint'(r.x_coord) << i, longint'(r.y_coord) << i, 0)
                << (n - 1 - i);
      end
      return saturate16(sum / (4 * ((longint'(1) << n) - 1)));
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      noise_request_type r;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req.opcode <= r.opcode;
            req.x_coord <= r.x_coord;
            req.y_coord <= r.y_coord;
            req.z_coord <= r.z_coord;
            req.entry_index <= r.entry_index;
            req.entry_value <= r.entry_value;
            req.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: a new readiness level each time a random countdown ends.
   int ready_pct = 100;
   int pattern_cnt = 0;
   always @(posedge clock) begin
      if (pattern_cnt == 0) begin
         pattern_cnt <= $urandom_range(50, 300);
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 75;
            2: ready_pct <= 40;
            default: ready_pct <= 10;
         endcase
      end else begin
         pattern_cnt <= pattern_cnt - 1;
      end
      rsp.ready <= ($urandom_range(0, 99) < ready_pct);
   end

   // Table copy or predictor per accepted request, checker on every accepted result.
   always @(posedge clock) begin
      noise_request_type r;
      logic signed [15:0] exp_v;
      if (!reset) begin
         if (req.valid && req.ready) begin
            r.opcode = opcode_type'(req.opcode);
            r.x_coord = req.x_coord;
            r.y_coord = req.y_coord;
            r.z_coord = req.z_coord;
            r.entry_index = req.entry_index;
            r.entry_value = req.entry_value;
            if (r.opcode == OP_LOAD) begin
               perm_copy[r.entry_index] = r.entry_value;
               load_count++;
            end else begin
               expected_noise.insert(expected_noise.size(), noise_prediction(r));
               eval_count++;
            end
         end
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (expected_noise.size() == 0) begin
               $error("unexpected result noise_value=%0d", rsp.noise_value);
               error_count++;
            end else begin
               exp_v = expected_noise.pop_front();
               if (rsp.noise_value !== exp_v) begin
                  $error("noise_value: expected %0d, actual %0d", exp_v, rsp.noise_value);
                  error_count++;
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any accepted request or result.
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == 3'd0) cur_mode = mode_type'(data[0]);
      else if (addr == 3'd4) cur_octaves = data[3:0];
   endtask

   task automatic push_eval(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      noise_request_type r;
      r.opcode = OP_EVAL;
      r.x_coord = x;
      r.y_coord = y;
      r.z_coord = z;
      r.entry_index = 9'($urandom);
      r.entry_value = 9'($urandom);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic push_load(input logic [8:0] idx, input logic [8:0] val);
      noise_request_type r;
      r.opcode = OP_LOAD;
      r.x_coord = $urandom;
      r.y_coord = $urandom;
      r.z_coord = $urandom;
      r.entry_index = idx;
      r.entry_value = val;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return {16'($urandom_range(0, 3) + 16'd510), 16'($urandom)};
      endcase
   endfunction

   // Wait for all requests taken and all results back, then let the pipeline settle.
   // The check runs on the falling edge, clear of the driver's updates.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req.valid || expected_noise.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] edge_vals[8];
      logic [3:0]  oct_settings[7];
      req.valid = 1'b0;
      req.opcode = 1'b0;
      req.x_coord = '0;
      req.y_coord = '0;
      req.z_coord = '0;
      req.entry_index = '0;
      req.entry_value = '0;
      rsp.ready = 1'b0;
      edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                    32'h0000FFFF, 32'hFFFF0000, 32'h01FF8000, 32'h00010000};
      oct_settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The whole table is written before any entry can be read.
      csr_write(3'd0, 32'(MODE_SINGLE));
      csr_write(3'd4, 32'd8);
      for (int i = 0; i < 512; i++) push_load(9'(i), (i % 3 == 0) ? 9'h1FF : 9'($urandom));
      push_load(9'h000, 9'h000);
      push_load(9'h1FF, 9'h1FF);

      // Directed: coordinate extremes on each axis.
      for (int i = 0; i < 8; i++) push_eval(edge_vals[i], edge_vals[7 - i], edge_vals[i]);
      push_eval(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_eval(32'h80000000, 32'h80000000, 32'h80000000);
      push_eval(32'h00008000, 32'h00008000, 32'h00008000);

      // Random phases, one setting each, single mode at both ends.
      for (int ph = 0; ph < 9; ph++) begin
         drain();
         if (ph == 0 || ph == 8) begin
            csr_write(3'd0, 32'(MODE_SINGLE));
         end else begin
            csr_write(3'd0, 32'(MODE_OCTAVE));
            csr_write(3'd4, 32'(oct_settings[ph - 1]));
            if (ph == 1) begin
               for (int i = 0; i < 4; i++) push_eval(edge_vals[i], edge_vals[i + 4], 32'h0);
            end
         end
         for (int i = 0; i < 115; i++) begin
            if ($urandom_range(0, 9) == 0) push_load(9'($urandom), 9'($urandom));
            else push_eval(random_coord(), random_coord(), random_coord());
         end
      end
      drain();

      $display("tb: %0d evaluate and %0d load requests, %0d results checked",
               eval_count, load_count, result_count);
      $display("tb: single mode and octave mode with counts 0, 1, 2, 3, 5, 8 and 15");
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
